// File: sv/plc_pkg.sv
package plc_pkg;

    typedef enum logic [1:0] {
        OP_F2L11 = 2'd0,
        OP_L112F = 2'd1,
        OP_F2U16 = 2'd2,
        OP_U162F = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] float_in;
        logic [15:0] code_in;
    } req_t;

    typedef struct packed {
        logic [31:0] float_out;
        logic [15:0] code_out;
        logic        ok;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic        neg;
        logic        ok;
        logic        sat;
        logic        zero;
        logic        rzero;
        logic [4:0]  rsh;
        logic [4:0]  l11_exp;
        logic [7:0]  base_exp;
        logic [23:0] mag;
    } s1_t;

    typedef struct packed {
        op_t         op;
        logic        neg;
        logic        ok;
        logic        sat;
        logic        zero;
        logic [4:0]  l11_exp;
        logic [7:0]  fexp;
        logic [15:0] val;
    } s2_t;

    localparam logic [7:0] EXP_INF    = 8'd255;
    localparam logic [7:0] EXP_SIXTEEN = 8'd131;
    localparam logic [7:0] BIAS       = 8'd127;
    localparam logic [7:0] U16_BASE   = 8'd115;
    localparam logic signed [9:0] L11_EXP_MIN = -10'sd16;
    localparam logic signed [9:0] L11_EXP_MAX = 10'sd15;
    localparam logic [15:0] U16_FULL  = 16'hFFFF;

endpackage

// File: sv/plc_unpack.sv
module plc_unpack (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  plc_pkg::req_t   request,
    output logic            out_valid,
    output plc_pkg::s1_t    stage
);

    plc_pkg::s1_t stage_reg;
    plc_pkg::s1_t stage_next;
    logic         valid_reg;

    logic              sgn;
    logic [7:0]        bexp;
    logic [22:0]       frac;
    logic signed [9:0] ecand;
    logic signed [9:0] esel;
    logic signed [9:0] rsh_l11;
    logic signed [9:0] rsh_u16;
    logic signed [10:0] mant11;
    logic [11:0]       mag11;

    always_comb
    begin
        sgn     = request.float_in[31];
        bexp    = request.float_in[30:23];
        frac    = request.float_in[22:0];
        mant11  = $signed(request.code_in[10:0]);
        mag11   = mant11[10] ? 12'(-mant11) : 12'(mant11);
        ecand   = $signed({2'b00, bexp}) - 10'sd136
                  - ((sgn && frac[22:13] == 10'd0) ? 10'sd1 : 10'sd0);
        esel    = (ecand < plc_pkg::L11_EXP_MIN) ? plc_pkg::L11_EXP_MIN : ecand;
        rsh_l11 = 10'sd150 + esel - $signed({2'b00, bexp});
        rsh_u16 = 10'sd138 - $signed({2'b00, bexp});

        stage_next          = '0;
        stage_next.op       = plc_pkg::op_t'(request.operation);
        stage_next.ok       = 1'b1;
        stage_next.mag      = {(bexp != 8'd0), frac};
        unique case (plc_pkg::op_t'(request.operation))
            plc_pkg::OP_F2L11:
            begin
                stage_next.neg     = sgn;
                stage_next.ok      = (bexp != plc_pkg::EXP_INF)
                                     && (esel <= plc_pkg::L11_EXP_MAX);
                stage_next.l11_exp = esel[4:0];
                stage_next.rzero   = rsh_l11 >= 10'sd24;
                stage_next.rsh     = rsh_l11[4:0];
            end
            plc_pkg::OP_F2U16:
            begin
                stage_next.ok    = !(sgn && (bexp != 8'd0 || frac != 23'd0))
                                   && (bexp < plc_pkg::EXP_SIXTEEN
                                       || (bexp == plc_pkg::EXP_SIXTEEN
                                           && frac == 23'd0));
                stage_next.sat   = bexp == plc_pkg::EXP_SIXTEEN;
                stage_next.rzero = rsh_u16 >= 10'sd24;
                stage_next.rsh   = rsh_u16[4:0];
            end
            plc_pkg::OP_L112F:
            begin
                stage_next.neg      = mant11[10];
                stage_next.zero     = mag11 == 12'd0;
                stage_next.mag      = {12'd0, mag11};
                stage_next.base_exp = plc_pkg::BIAS
                                      + {{3{request.code_in[15]}}, request.code_in[15:11]};
            end
            plc_pkg::OP_U162F:
            begin
                stage_next.zero     = request.code_in == 16'd0;
                stage_next.mag      = {8'd0, request.code_in};
                stage_next.base_exp = plc_pkg::U16_BASE;
            end
            default:
            begin
                stage_next.ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign stage     = stage_reg;

endmodule

// File: sv/plc_shift.sv
module plc_shift (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  plc_pkg::s1_t  stage_in,
    output logic          out_valid,
    output plc_pkg::s2_t  stage_out
);

    plc_pkg::s2_t stage_reg;
    plc_pkg::s2_t stage_next;
    logic         valid_reg;
    logic [3:0]   msb;
    logic [23:0]  shifted;

    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (stage_in.mag[i])
            begin
                msb = 4'(i);
            end
        end
        shifted = stage_in.rzero ? 24'd0 : (stage_in.mag >> stage_in.rsh);

        stage_next         = '0;
        stage_next.op      = stage_in.op;
        stage_next.neg     = stage_in.neg;
        stage_next.ok      = stage_in.ok;
        stage_next.sat     = stage_in.sat;
        stage_next.zero    = stage_in.zero;
        stage_next.l11_exp = stage_in.l11_exp;
        stage_next.fexp    = stage_in.base_exp + {4'd0, msb};
        case (stage_in.op) inside
            plc_pkg::OP_F2L11, plc_pkg::OP_F2U16:
            begin
                stage_next.val = shifted[15:0];
            end
            default:
            begin
                stage_next.val = stage_in.mag[15:0] << (4'd15 - msb);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign stage_out = stage_reg;

endmodule

// File: sv/plc_pack.sv
module plc_pack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  plc_pkg::s2_t  stage_in,
    output logic          out_valid,
    output plc_pkg::rsp_t result
);

    plc_pkg::rsp_t result_reg;
    plc_pkg::rsp_t result_next;
    logic          valid_reg;
    logic [10:0]   mant;

    always_comb
    begin
        mant        = stage_in.neg ? 11'(-stage_in.val[10:0]) : stage_in.val[10:0];
        result_next = '0;
        result_next.ok = stage_in.ok;
        unique case (stage_in.op) inside
            plc_pkg::OP_F2L11:
            begin
                result_next.code_out = stage_in.ok ? {stage_in.l11_exp, mant} : 16'd0;
            end
            plc_pkg::OP_F2U16:
            begin
                if (!stage_in.ok)
                begin
                    result_next.code_out = 16'd0;
                end
                else if (stage_in.sat)
                begin
                    result_next.code_out = plc_pkg::U16_FULL;
                end
                else
                begin
                    result_next.code_out = stage_in.val;
                end
            end
            plc_pkg::OP_L112F, plc_pkg::OP_U162F:
            begin
                result_next.ok        = 1'b1;
                result_next.float_out = stage_in.zero ? 32'd0
                    : {stage_in.neg, stage_in.fexp, stage_in.val[14:0], 8'd0};
            end
            default:
            begin
                result_next.ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// File: sv/pmbus_linear_format_converter.sv
// Channel   Handshake      Payload
// request   start / busy   operation, float_in, code_in
// result    done           float_out, code_out, ok
//
// Every beat passes the unpack, shift and pack registers from acceptance to its done strobe.
// A new beat is accepted in every cycle, so busy stays low.
// The three stages are unpack and classify, shift and count, and pack.
// Reset clears the valid bits only, and the result is held for exactly one cycle.
module pmbus_linear_format_converter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  plc_pkg::req_t request,
    output logic          done,
    output plc_pkg::rsp_t result
);

    logic         v1;
    logic         v2;
    plc_pkg::s1_t s1;
    plc_pkg::s2_t s2;

    assign busy = 1'b0;

    plc_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .request   (request),
        .out_valid (v1),
        .stage     (s1)
    );

    plc_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .stage_in  (s1),
        .out_valid (v2),
        .stage_out (s2)
    );

    plc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .stage_in  (s2),
        .out_valid (done),
        .result    (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done)
        else $error("accepted beat did not complete after three cycles");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ok |-> result.code_out == 16'd0 && result.float_out == 32'd0)
        else $error("failed conversion returned a nonzero word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result strobe without an accepted beat");

endmodule
